@@ hdl/b64enc_pkg.sv @@
// Shared types and constants of the base64 stream encoder.
// Holds the job record passed from the front end to the character emitter.
// No dependencies.
package b64enc_pkg;

  // Most characters one input item can produce (one-byte tail plus newline)
  localparam int unsigned JOB_CHARS = 5;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W    = 1;

  localparam logic [6:0] CHAR_PAD   = 7'h3D;  // '='
  localparam logic [6:0] CHAR_NL    = 7'h0A;  // newline
  localparam logic [6:0] CHAR_PLUS  = 7'h2B;  // '+'
  localparam logic [6:0] CHAR_SLASH = 7'h2F;  // '/'

  // Group phase codes
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  // Configuration register indexes
  localparam logic REG_WRAP_ENABLE = 1'b0;

  typedef logic [JOB_CHARS-1:0][6:0] char_vec_t;

  // One input item's worth of output characters
  typedef struct packed {
    char_vec_t        chars;
    logic [CNT_W-1:0] count;
    logic             last;
  } job_t;

  // Standard alphabet lookup of one 6-bit value
  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] c;
    if (v < 6'd26) begin
      c = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'h61 + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      c = 7'h30 + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

endpackage

@@ hdl/b64enc_front.sv @@
// Front end of the base64 encoder: takes bytes, tracks the group and line
// position and builds one job of output characters per byte.
// Depends on b64enc_pkg.
module b64enc_front #(
  parameter int unsigned LINE_BYTES = 57
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wrap_enable,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  input  logic               q_full,
  output logic               job_push,
  output b64enc_pkg::job_t   job
);
  import b64enc_pkg::*;

  localparam int unsigned GPL_RAW = LINE_BYTES / 3;
  localparam int unsigned GPL     = (GPL_RAW == 0) ? 1 : GPL_RAW;
  localparam int unsigned GCW     = (GPL > 1) ? $clog2(GPL) : 1;
  localparam logic [GCW-1:0] GCNT_LAST = GCW'(GPL - 1);

  logic [1:0]     phase_r, phase_nxt;
  logic [3:0]     held_r, held_nxt;
  logic [GCW-1:0] gcnt_r, gcnt_nxt;
  logic           line_end;

  assign in_ready = !q_full;
  assign job_push = in_valid && in_ready;
  assign line_end = (gcnt_r == GCNT_LAST);

  // Character selection and next position
  always_comb begin
    job.chars = '{default: CHAR_PAD};
    job.count = '0;
    job.last  = in_last_byte;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    gcnt_nxt  = gcnt_r;
    case (phase_r)
      PH_SECOND: begin
        job.chars[0] = b64_char({held_r[1:0], in_data_byte[7:4]});
        job.count    = CNT_W'(1);
        held_nxt     = in_data_byte[3:0];
        phase_nxt    = PH_THIRD;
        if (in_last_byte) begin
          job.chars[1] = b64_char({in_data_byte[3:0], 2'b00});
          job.chars[2] = CHAR_PAD;
          job.chars[3] = CHAR_NL;
          job.count    = wrap_enable ? CNT_W'(4) : CNT_W'(3);
        end
      end
      PH_THIRD: begin
        job.chars[0] = b64_char({held_r, in_data_byte[7:6]});
        job.chars[1] = b64_char(in_data_byte[5:0]);
        job.chars[2] = CHAR_NL;
        job.count    = (wrap_enable && (line_end || in_last_byte)) ? CNT_W'(3) : CNT_W'(2);
        held_nxt     = '0;
        phase_nxt    = PH_FIRST;
        gcnt_nxt     = line_end ? '0 : gcnt_r + GCW'(1);
      end
      default: begin
        job.chars[0] = b64_char(in_data_byte[7:2]);
        job.count    = CNT_W'(1);
        held_nxt     = {2'b00, in_data_byte[1:0]};
        phase_nxt    = PH_SECOND;
        if (in_last_byte) begin
          job.chars[1] = b64_char({in_data_byte[1:0], 4'b0000});
          job.chars[2] = CHAR_PAD;
          job.chars[3] = CHAR_PAD;
          job.chars[4] = CHAR_NL;
          job.count    = wrap_enable ? CNT_W'(5) : CNT_W'(4);
        end
      end
    endcase
    // end of buffer returns to the start of a line
    if (in_last_byte) begin
      phase_nxt = PH_FIRST;
      held_nxt  = '0;
      gcnt_nxt  = '0;
    end
  end

  // Position state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      held_r  <= '0;
      gcnt_r  <= '0;
    end else if (job_push) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      gcnt_r  <= gcnt_nxt;
    end
  end

endmodule

@@ hdl/b64enc_queue.sv @@
// Short job queue between the encoder front end and the character emitter.
// Register-based FIFO of job records. Depends on b64enc_pkg.
module b64enc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  b64enc_pkg::job_t push_job,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output b64enc_pkg::job_t head
);
  import b64enc_pkg::*;

  job_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   fill_r, fill_nxt;

  assign full      = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (fill_r != '0);
  assign head      = entry_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (QPTR_W+1)'(1);
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      fill_r <= fill_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_job;
  end

endmodule

@@ hdl/b64enc_back.sv @@
// Character emitter of the base64 encoder: walks the head job of the queue
// and hands out one character per accepted output item. Depends on b64enc_pkg.
module b64enc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  input  b64enc_pkg::job_t job,
  output logic             job_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [6:0]       out_char,
  output logic             out_last
);
  import b64enc_pkg::*;

  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             final_char;

  assign out_valid  = job_valid;
  assign final_char = (idx_r == job.count - CNT_W'(1));
  assign out_last   = job.last && final_char;
  assign job_pop    = out_valid && out_ready && final_char;

  // Character select within the job
  always_comb begin
    case (idx_r)
      3'd0:    out_char = job.chars[0];
      3'd1:    out_char = job.chars[1];
      3'd2:    out_char = job.chars[2];
      3'd3:    out_char = job.chars[3];
      3'd4:    out_char = job.chars[4];
      default: out_char = CHAR_PAD;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (out_valid && out_ready) begin
      idx_nxt = final_char ? '0 : idx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

@@ hdl/base64_stream_encoder.sv @@
// Top level of the base64 stream encoder with optional 76-column wrapping.
// Instantiates b64enc_front, b64enc_queue and b64enc_back; uses b64enc_pkg.
//
// Usage:
//   Input channel (in_*): one byte per item, in_last_byte marks the end of a
//   buffer. Output channel (out_*): one ASCII character per item, out_last on
//   the final character of a buffer (pad or newline included).
//   Config port (cfg_*): register 0 at byte address 0, bit 0 = wrap_enable;
//   write only while the encoder is idle. cfg_pready is tied high.
// Timing:
//   A byte is accepted whenever the two-entry job queue has room; with the
//   queue empty its first character is offered on the cycle after acceptance.
//   The output side emits one character per cycle while out_ready is high;
//   a byte yields 1 to 2 characters in a group (4 characters per 3 bytes), 3 at a
//   line break, and up to 5 for a buffer tail; sustained rate is set by the
//   single-character output port.
// Reset: synchronous, active low; clears group, line position, queue and
//   wrap_enable.
// Stall: when out_ready is low the queue fills and in_ready drops after two
//   bytes are buffered; nothing is lost.
module base64_stream_encoder #(
  parameter int unsigned LINE_BYTES = 57
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_char,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import b64enc_pkg::*;

  logic wrap_r;
  logic q_full, q_not_empty, job_push, job_pop;
  job_t front_job, head_job;

  // Configuration register
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_WRAP_ENABLE)) begin
      wrap_r <= cfg_pwdata[0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == REG_WRAP_ENABLE) ? {31'd0, wrap_r} : 32'd0;

  b64enc_front #(
    .LINE_BYTES(LINE_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .wrap_enable (wrap_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .q_full      (q_full),
    .job_push    (job_push),
    .job         (front_job)
  );

  b64enc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (front_job),
    .full     (q_full),
    .pop      (job_pop),
    .not_empty(q_not_empty),
    .head     (head_job)
  );

  b64enc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(q_not_empty),
    .job      (head_job),
    .job_pop  (job_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char (out_char),
    .out_last (out_last)
  );

endmodule
